// ===== hdl/nbsg_pkg.sv =====
// ----------------------------------------------------------------------------
// nbsg_pkg
// Shared types and constants of the softened-gravity acceleration engine.
// ----------------------------------------------------------------------------
package nbsg_pkg;

    // field widths
    localparam int POS_W  = 64;
    localparam int VEL_W  = 48;
    localparam int MASS_W = 62;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int SOFT_W = 63;
    localparam int ACC_W  = 128;
    localparam int OUT_W  = 64;

    // shared adder width and datapath widths
    localparam int WW     = 240;
    localparam int R2_W   = 130;
    localparam int RAD_W  = 132;
    localparam int ROOT_W = 66;
    localparam int REM_W  = 70;
    localparam int MP_W   = 66;
    localparam int DEN_W  = 239;
    localparam int MK_W   = 72;
    localparam int P_W    = 136;
    localparam int Q_W    = 100;
    // product bits below the quotient window enter the divider one per step
    localparam int DIV_LO = 28;
    localparam int STEP_W = 7;
    localparam int SQRT_STEPS = 66;
    localparam int DIV_STEPS  = 100;

    // gravitational constant as 667 / 10^13
    localparam logic [43:0]       G_DEN      = 44'd10000000000000;
    localparam logic [9:0]        G_NUM      = 10'd667;
    localparam logic [SOFT_W-1:0] SOFT_RESET = 63'd1000000000000;
    localparam logic [OUT_W-1:0]  ACC_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0]  ACC_MIN    = 64'h8000_0000_0000_0000;

    // stream layout
    localparam int S_DATA_W = 408;
    localparam int M_DATA_W = 352;
    localparam int M_PAD_W  = 6;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_BODY_COUNT   = 2'd0,
        REG_SOFTENING_SQ = 2'd1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WAIT_I,
        ST_GET_I,
        ST_NEXT,
        ST_WAIT_J,
        ST_GET_J,
        ST_SIGN,
        ST_MAG,
        ST_SQ_SET,
        ST_SQ_MUL,
        ST_SQRT,
        ST_DEN1_MUL,
        ST_DEN2_MUL,
        ST_MASS_MUL,
        ST_AX_SET,
        ST_NUM_MUL,
        ST_DIV_CHK,
        ST_DIV,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [VEL_W-1:0]  vel_x;
        logic [VEL_W-1:0]  vel_y;
        logic [VEL_W-1:0]  vel_z;
        logic [MASS_W-1:0] mass;
    } body_t;

    typedef struct packed {
        logic [WW-1:0] a;
        logic [WW-1:0] b;
        logic          sub;
    } alu_req_t;

    typedef struct packed {
        logic [WW-1:0] res;
        logic          carry;
    } alu_rsp_t;

    typedef struct packed {
        logic start;
        logic res_ready;
    } eng_ctl_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_sts_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [VEL_W-1:0] dpos_x;
        logic [VEL_W-1:0] dpos_y;
        logic [VEL_W-1:0] dpos_z;
        logic [OUT_W-1:0] acc_x;
        logic [OUT_W-1:0] acc_y;
        logic [OUT_W-1:0] acc_z;
    } result_t;

    function automatic logic [WW-1:0] sext_pos(input logic [POS_W-1:0] v);
        return {{(WW-POS_W){v[POS_W-1]}}, v};
    endfunction

endpackage

// ===== hdl/nbsg_store.sv =====
// ----------------------------------------------------------------------------
// nbsg_store
// Body memory: position, velocity and mass of every body, one row per body.
// ----------------------------------------------------------------------------
module nbsg_store
    import nbsg_pkg::*;
#(
    parameter int MAX_BODIES = 1024,
    localparam int AW = $clog2(MAX_BODIES)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  body_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output body_t         rd_data
);

    body_t mem [MAX_BODIES];
    body_t rd_data_reg;

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/nbsg_alu.sv =====
// ----------------------------------------------------------------------------
// nbsg_alu
// Shared wide adder/subtractor; carry out high on subtract means a >= b.
// ----------------------------------------------------------------------------
module nbsg_alu
    import nbsg_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [WW-1:0] b_eff;
    logic [WW:0]   sum;

    // two's complement subtract by inverting b and adding one
    assign b_eff = req.sub ? ~req.b : req.b;
    assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{WW{1'b0}}, req.sub};

    assign rsp.res   = sum[WW-1:0];
    assign rsp.carry = sum[WW];

endmodule

// ===== hdl/nbsg_engine.sv =====
// ----------------------------------------------------------------------------
// nbsg_engine
// Sequencer and datapath registers: walks the bodies and forms each pair
// term with bit-serial multiplies, a digit square root and a long division,
// all on the shared adder.
// ----------------------------------------------------------------------------
module nbsg_engine
    import nbsg_pkg::*;
#(
    parameter int MAX_BODIES = 1024,
    localparam int AW = $clog2(MAX_BODIES),
    localparam int JW = $clog2(MAX_BODIES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  eng_ctl_t          ctl,
    input  logic [IDX_W-1:0]  start_idx,
    input  logic [CNT_W-1:0]  body_count,
    input  logic [SOFT_W-1:0] softening_sq,
    output logic [AW-1:0]     rd_addr,
    input  body_t             rd_data,
    output eng_sts_t          sts,
    output result_t           result
);

    state_t state_reg, state_next;

    logic [AW-1:0]    addr_reg, addr_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       ax_reg, ax_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    logic [2:0][POS_W-1:0] pi_reg, pi_next;
    logic [2:0][POS_W-1:0] pj_reg, pj_next;
    logic [2:0][VEL_W-1:0] vi_reg, vi_next;
    logic [2:0][POS_W-1:0] mag_reg, mag_next;
    logic [2:0]            neg_reg, neg_next;
    logic [MASS_W-1:0]     mj_reg, mj_next;

    logic [WW-1:0]     prod_reg, prod_next;
    logic [WW-1:0]     mc_reg, mc_next;
    logic [MP_W-1:0]   mp_reg, mp_next;
    logic [R2_W-1:0]   r2_reg, r2_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [MK_W-1:0]   mk_reg, mk_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [2:0][ACC_W-1:0] acc_reg, acc_next;

    alu_req_t      req;
    alu_rsp_t      rsp;
    logic          mul_run;
    logic [31:0]   count_lim;
    logic [REM_W-1:0] rem_shift;
    logic [WW-1:0] div_shift;

    // clamp the body count to the store depth
    assign count_lim = (32'(body_count) > 32'(MAX_BODIES)) ? 32'(MAX_BODIES)
                                                           : 32'(body_count);
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign div_shift = {prod_reg[WW-2:0], mc_reg[WW-1]};

    nbsg_alu u_alu (
        .req (req),
        .rsp (rsp)
    );

    // saturate the 128-bit sum to the signed 64-bit range
    function automatic logic [OUT_W-1:0] sat64(input logic [ACC_W-1:0] v);
        logic [ACC_W-OUT_W:0] upper;
        upper = v[ACC_W-1:OUT_W-1];
        if (upper == '0 || upper == '1) begin
            return v[OUT_W-1:0];
        end else if (v[ACC_W-1]) begin
            return ACC_MIN;
        end else begin
            return ACC_MAX;
        end
    endfunction

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        j_reg    <= j_next;
        idx_reg  <= idx_next;
        ax_reg   <= ax_next;
        cnt_reg  <= cnt_next;
        pi_reg   <= pi_next;
        pj_reg   <= pj_next;
        vi_reg   <= vi_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        mj_reg   <= mj_next;
        prod_reg <= prod_next;
        mc_reg   <= mc_next;
        mp_reg   <= mp_next;
        r2_reg   <= r2_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        den_reg  <= den_next;
        mk_reg   <= mk_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
    end

    // sequencer: next state and datapath control
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        j_next     = j_reg;
        idx_next   = idx_reg;
        ax_next    = ax_reg;
        cnt_next   = cnt_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        vi_next    = vi_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        mj_next    = mj_reg;
        prod_next  = prod_reg;
        mc_next    = mc_reg;
        mp_next    = mp_reg;
        r2_next    = r2_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        den_next   = den_reg;
        mk_next    = mk_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        req        = '0;
        mul_run    = 1'b0;
        sts.idle      = 1'b0;
        sts.res_valid = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                sts.idle = 1'b1;
                if (ctl.start) begin
                    idx_next   = start_idx;
                    addr_next  = AW'(start_idx);
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = ST_WAIT_I;
                end
            end
            ST_WAIT_I: begin
                state_next = ST_GET_I;
            end
            ST_GET_I: begin
                pi_next[0] = rd_data.pos_x;
                pi_next[1] = rd_data.pos_y;
                pi_next[2] = rd_data.pos_z;
                vi_next[0] = rd_data.vel_x;
                vi_next[1] = rd_data.vel_y;
                vi_next[2] = rd_data.vel_z;
                state_next = ST_NEXT;
            end
            // pick the next partner body, skipping the evaluated one
            ST_NEXT: begin
                if (32'(j_reg) >= count_lim) begin
                    state_next = ST_FIN;
                end else if (32'(j_reg) == 32'(idx_reg)) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    addr_next  = AW'(j_reg);
                    state_next = ST_WAIT_J;
                end
            end
            ST_WAIT_J: begin
                state_next = ST_GET_J;
            end
            ST_GET_J: begin
                pj_next[0] = rd_data.pos_x;
                pj_next[1] = rd_data.pos_y;
                pj_next[2] = rd_data.pos_z;
                mj_next    = rd_data.mass;
                ax_next    = '0;
                state_next = ST_SIGN;
            end
            // sign of the separation on this axis
            ST_SIGN: begin
                req.a = sext_pos(pj_reg[ax_reg]);
                req.b = sext_pos(pi_reg[ax_reg]);
                req.sub = 1'b1;
                neg_next[ax_reg] = rsp.res[WW-1];
                state_next = ST_MAG;
            end
            // magnitude of the separation
            ST_MAG: begin
                req.a = neg_reg[ax_reg] ? sext_pos(pi_reg[ax_reg]) : sext_pos(pj_reg[ax_reg]);
                req.b = neg_reg[ax_reg] ? sext_pos(pj_reg[ax_reg]) : sext_pos(pi_reg[ax_reg]);
                req.sub = 1'b1;
                mag_next[ax_reg] = rsp.res[POS_W-1:0];
                if (ax_reg == 2'd2) begin
                    ax_next    = '0;
                    prod_next  = WW'(softening_sq);
                    state_next = ST_SQ_SET;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_SIGN;
                end
            end
            ST_SQ_SET: begin
                mc_next    = WW'(mag_reg[ax_reg]);
                mp_next    = MP_W'(mag_reg[ax_reg]);
                state_next = ST_SQ_MUL;
            end
            // squares accumulate onto the softening term
            ST_SQ_MUL: begin
                if (mp_reg == '0) begin
                    if (ax_reg == 2'd2) begin
                        r2_next = prod_reg[R2_W-1:0];
                        if (prod_reg == '0) begin
                            j_next     = j_reg + 1'b1;
                            state_next = ST_NEXT;
                        end else begin
                            rad_next   = RAD_W'(prod_reg[R2_W-1:0]);
                            rem_next   = '0;
                            root_next  = '0;
                            cnt_next   = STEP_W'(SQRT_STEPS);
                            state_next = ST_SQRT;
                        end
                    end else begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_SQ_SET;
                    end
                end else begin
                    mul_run = 1'b1;
                end
            end
            // one root bit per step from two radicand bits
            ST_SQRT: begin
                req.a   = WW'(rem_shift);
                req.b   = WW'({root_reg, 2'b01});
                req.sub = 1'b1;
                if (rsp.carry) begin
                    rem_next = rsp.res[REM_W-1:0];
                end else begin
                    rem_next = rem_shift;
                end
                root_next = {root_reg[ROOT_W-2:0], rsp.carry};
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    prod_next  = '0;
                    mc_next    = WW'(r2_reg);
                    mp_next    = MP_W'(G_DEN);
                    state_next = ST_DEN1_MUL;
                end
            end
            ST_DEN1_MUL: begin
                if (mp_reg == '0) begin
                    mc_next    = prod_reg;
                    mp_next    = root_reg;
                    prod_next  = '0;
                    state_next = ST_DEN2_MUL;
                end else begin
                    mul_run = 1'b1;
                end
            end
            ST_DEN2_MUL: begin
                if (mp_reg == '0) begin
                    den_next   = prod_reg[DEN_W-1:0];
                    prod_next  = '0;
                    mc_next    = WW'(mj_reg);
                    mp_next    = MP_W'(G_NUM);
                    state_next = ST_MASS_MUL;
                end else begin
                    mul_run = 1'b1;
                end
            end
            ST_MASS_MUL: begin
                if (mp_reg == '0) begin
                    mk_next    = prod_reg[MK_W-1:0];
                    ax_next    = '0;
                    state_next = ST_AX_SET;
                end else begin
                    mul_run = 1'b1;
                end
            end
            // axes with no separation add nothing
            ST_AX_SET: begin
                if (mag_reg[ax_reg] == '0) begin
                    if (ax_reg == 2'd2) begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_NEXT;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end else begin
                    prod_next  = '0;
                    mc_next    = WW'(mk_reg);
                    mp_next    = MP_W'(mag_reg[ax_reg]);
                    state_next = ST_NUM_MUL;
                end
            end
            ST_NUM_MUL: begin
                if (mp_reg == '0) begin
                    state_next = ST_DIV_CHK;
                end else begin
                    mul_run = 1'b1;
                end
            end
            // quotient of 2^100 or more saturates the pair term
            ST_DIV_CHK: begin
                req.a   = WW'(prod_reg[P_W-1:DIV_LO]);
                req.b   = WW'(den_reg);
                req.sub = 1'b1;
                if (rsp.carry) begin
                    q_next     = '1;
                    state_next = ST_ACC;
                end else begin
                    prod_next  = WW'(prod_reg[P_W-1:DIV_LO]);
                    mc_next    = {prod_reg[DIV_LO-1:0], {(WW-DIV_LO){1'b0}}};
                    q_next     = '0;
                    cnt_next   = STEP_W'(DIV_STEPS);
                    state_next = ST_DIV;
                end
            end
            // restoring division, one quotient bit per step
            ST_DIV: begin
                req.a   = div_shift;
                req.b   = WW'(den_reg);
                req.sub = 1'b1;
                if (rsp.carry) begin
                    prod_next = rsp.res;
                end else begin
                    prod_next = div_shift;
                end
                q_next   = {q_reg[Q_W-2:0], rsp.carry};
                mc_next  = mc_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                req.a   = WW'(acc_reg[ax_reg]);
                req.b   = WW'(q_reg);
                req.sub = neg_reg[ax_reg];
                acc_next[ax_reg] = rsp.res[ACC_W-1:0];
                if (ax_reg == 2'd2) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_NEXT;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_AX_SET;
                end
            end
            ST_FIN: begin
                sts.res_valid = 1'b1;
                if (ctl.res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // shift-and-add multiply step
        if (mul_run) begin
            req.a   = prod_reg;
            req.b   = mc_reg;
            req.sub = 1'b0;
            if (mp_reg[0]) begin
                prod_next = rsp.res;
            end
            mc_next = mc_reg << 1;
            mp_next = mp_reg >> 1;
        end
    end

    assign rd_addr = addr_reg;

    // result fields
    assign result.out_index = idx_reg;
    assign result.dpos_x    = vi_reg[0];
    assign result.dpos_y    = vi_reg[1];
    assign result.dpos_z    = vi_reg[2];
    assign result.acc_x     = sat64(acc_reg[0]);
    assign result.acc_y     = sat64(acc_reg[1]);
    assign result.acc_z     = sat64(acc_reg[2]);

endmodule

// ===== hdl/nbody_softened_gravity_accel.sv =====
// ----------------------------------------------------------------------------
// nbody_softened_gravity_accel
// Direct-sum gravity engine with softening: load and evaluate bodies.
// ----------------------------------------------------------------------------
// Load: the body row is written at the transfer.
// Evaluate: each partner body goes through the bit-serial multiplies, the
//   66-step square root and the 100-step divisions that all run on the
//   single 240-bit adder; a pair with zero softened distance stops after
//   the squares.
// One item at a time; a finished result waits in the output register.
// Reset is synchronous, active low: clears the sequencer, output valid,
//   body_count to 0 and softening_sq to 10^12; the body memory is kept.
module nbody_softened_gravity_accel
    import nbsg_pkg::*;
#(
    parameter int MAX_BODIES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // body_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass
    input  logic [S_DATA_W-1:0] s_tdata,
    // op
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_index, dpos_x, dpos_y, dpos_z, acc_x, acc_y, acc_z, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [SOFT_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(MAX_BODIES);

    logic [CNT_W-1:0]    body_count_reg;
    logic [SOFT_W-1:0]   softening_sq_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0] s_body_index;
    body_t            s_body;
    logic             s_xfer;
    logic             in_range;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    body_t            rd_data;
    eng_ctl_t         ctl;
    eng_sts_t         sts;
    result_t          result;

    // unpack the input transfer
    assign s_body_index  = s_tdata[9:0];
    assign s_body.pos_x  = s_tdata[73:10];
    assign s_body.pos_y  = s_tdata[137:74];
    assign s_body.pos_z  = s_tdata[201:138];
    assign s_body.vel_x  = s_tdata[249:202];
    assign s_body.vel_y  = s_tdata[297:250];
    assign s_body.vel_z  = s_tdata[345:298];
    assign s_body.mass   = s_tdata[407:346];

    assign s_tready = sts.idle;
    assign s_xfer   = s_tvalid && s_tready;
    assign in_range = 32'(s_body_index) < 32'(MAX_BODIES);
    assign wr_en    = s_xfer && (s_tuser == OP_LOAD) && in_range;

    assign ctl.start     = s_xfer && (s_tuser == OP_EVAL) && in_range;
    assign ctl.res_ready = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_count_reg   <= '0;
            softening_sq_reg <= SOFT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_BODY_COUNT) begin
                body_count_reg <= cfg_wdata[CNT_W-1:0];
            end else if (cfg_index == REG_SOFTENING_SQ) begin
                softening_sq_reg <= cfg_wdata;
            end
        end
    end

    nbsg_store #(
        .MAX_BODIES (MAX_BODIES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_body_index)),
        .wr_data (s_body),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nbsg_engine #(
        .MAX_BODIES (MAX_BODIES)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .start_idx    (s_body_index),
        .body_count   (body_count_reg),
        .softening_sq (softening_sq_reg),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .sts          (sts),
        .result       (result)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (sts.res_valid && ctl.res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, result.acc_z, result.acc_y,
                             result.acc_x, result.dpos_z, result.dpos_y,
                             result.dpos_x, result.out_index};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/nbsg_checker.sv =====
// ----------------------------------------------------------------------------
// nbsg_checker
// Port-level checks of the gravity engine, bound to the top level.
// ----------------------------------------------------------------------------
module nbsg_checker
    import nbsg_pkg::*;
#(
    parameter int MAX_BODIES = 1024
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // no result is offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a load transfer never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_LOAD |=> !$rose(m_tvalid))
        else $error("result after load");

    // an evaluate in range occupies the engine
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_EVAL &&
        (32'(s_tdata[9:0]) < 32'(MAX_BODIES)) |=> !s_tready)
        else $error("ready while evaluating");

endmodule

bind nbody_softened_gravity_accel nbsg_checker #(
    .MAX_BODIES (MAX_BODIES)
) u_nbsg_checker (.*);
